// File: rtl/escaped_frame_varint_deframer_top_defines.svh
// Assertion macros for the deframer RTL (used by efvd_back).
`ifndef ESCAPED_FRAME_VARINT_DEFRAMER_TOP_DEFINES_SVH
`define ESCAPED_FRAME_VARINT_DEFRAMER_TOP_DEFINES_SVH

`ifndef SYNTH
// Clocked check, off while reset is asserted.
`define EFVD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// Clocked implication, off while reset is asserted.
`define EFVD_ASSERT_IMP(lbl, pre, post) \
  `EFVD_ASSERT(lbl, (pre) |-> (post))
`else
`define EFVD_ASSERT(lbl, prop)
`define EFVD_ASSERT_IMP(lbl, pre, post)
`endif

`endif

// File: rtl/efvd_pkg.sv
package efvd_pkg;

  localparam logic [7:0] StartByte  = 8'd250;
  localparam logic [7:0] EscByte    = 8'd249;
  localparam logic [7:0] EscCodeStart = 8'd0;
  localparam logic [7:0] EscCodeEsc   = 8'd1;
  localparam logic [7:0] ChanNone   = 8'd0;
  localparam logic [7:0] ChanRawA   = 8'd96;
  localparam logic [7:0] ChanRawB   = 8'd97;
  localparam logic [7:0] ChanRawC   = 8'd98;

  localparam int unsigned MaxWords = 1024;
  localparam int unsigned PosW     = 11;
  localparam logic [PosW-1:0] MaxPos = PosW'(MaxWords);

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic {
    OP_DATA  = 1'b0,
    OP_BOUND = 1'b1
  } op_kind_e;

  typedef enum logic [1:0] {
    KIND_WORD = 2'd0,
    KIND_RAW  = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  typedef struct packed {
    op_kind_e   op;
    logic [7:0] data;
  } op_t;

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       chan;
    logic [31:0]      value;
    logic [PosW-1:0]  pos;
    logic             over;
  } res_t;

endpackage

// File: rtl/efvd_front.sv
module efvd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      byte_in_i,
  input  logic            q_full_i,
  output logic            push_o,
  output efvd_pkg::op_t   op_o
);
  import efvd_pkg::*;

  logic esc_q, esc_d;
  logic accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    esc_d     = esc_q;
    push_o    = 1'b0;
    op_o.op   = OP_DATA;
    op_o.data = byte_in_i;
    if (accept) begin
      if (byte_in_i == StartByte) begin
        // boundary keeps any pending escape
        push_o  = 1'b1;
        op_o.op = OP_BOUND;
      end else if (byte_in_i == EscByte) begin
        esc_d = 1'b1;
      end else if (esc_q) begin
        esc_d = 1'b0;
        if (byte_in_i == EscCodeStart) begin
          push_o    = 1'b1;
          op_o.data = StartByte;
        end else if (byte_in_i == EscCodeEsc) begin
          push_o    = 1'b1;
          op_o.data = EscByte;
        end
      end else begin
        push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= 1'b0;
    end else begin
      esc_q <= esc_d;
    end
  end

endmodule

// File: rtl/efvd_fifo.sv
module efvd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  efvd_pkg::op_t  push_op_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output efvd_pkg::op_t  head_o
);
  import efvd_pkg::*;

  op_t                mem_q [QDepth];
  logic [QPtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;
  logic               do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({push_i, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: rtl/efvd_back.sv
`include "escaped_frame_varint_deframer_top_defines.svh"

module efvd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  efvd_pkg::op_t   head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output efvd_pkg::res_t  res_o
);
  import efvd_pkg::*;

  logic            await_q, await_d;
  logic [7:0]      chan_q, chan_d;
  logic [31:0]     acc_q, acc_d;
  logic [31:0]     acc_new;
  logic [PosW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic            out_valid_q, out_valid_d;
  res_t            res_q, res;
  logic            emit;
  logic            ready;
  logic            special;

  assign ready   = !out_valid_q || !out_stall_i;
  assign pop_o   = ready && q_valid_i;
  assign special = (chan_q == ChanRawA) || (chan_q == ChanRawB) || (chan_q == ChanRawC);
  assign acc_new = {acc_q[24:0], head_i.data[6:0]};

  always_comb begin
    await_d   = await_q;
    chan_d    = chan_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    emit      = 1'b0;
    res.kind  = KIND_WORD;
    res.chan  = chan_q;
    res.value = '0;
    res.pos   = '0;
    res.over  = 1'b0;
    if (pop_o) begin
      unique case (head_i.op)
        OP_BOUND: begin
          if (!await_q && chan_q != ChanNone) begin
            emit     = 1'b1;
            res.kind = KIND_END;
            res.pos  = cnt_q;
            res.over = ovf_q;
          end
          await_d = 1'b1;
          acc_d   = '0;
          cnt_d   = '0;
          ovf_d   = 1'b0;
        end
        OP_DATA: begin
          if (await_q) begin
            chan_d  = head_i.data;
            await_d = 1'b0;
          end else if (special) begin
            emit      = 1'b1;
            res.kind  = KIND_RAW;
            res.value = {24'd0, head_i.data};
          end else if (head_i.data[7]) begin
            acc_d = acc_new;
          end else begin
            emit      = 1'b1;
            res.value = acc_new;
            res.pos   = cnt_q;
            res.over  = (cnt_q >= MaxPos);
            if (cnt_q >= MaxPos) begin
              ovf_d = 1'b1;
            end else begin
              cnt_d = cnt_q + 1'b1;
            end
            acc_d = '0;
          end
        end
        default: ;
      endcase
    end
    out_valid_d = ready ? emit : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      await_q     <= 1'b0;
      chan_q      <= '0;
      acc_q       <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      await_q     <= await_d;
      chan_q      <= chan_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && emit) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  `EFVD_ASSERT(a_cnt_sat, cnt_q <= MaxPos)
  `EFVD_ASSERT_IMP(a_over_pos, out_valid_q && res_q.kind == KIND_WORD && res_q.over, res_q.pos == MaxPos)
  `EFVD_ASSERT_IMP(a_raw_fields, out_valid_q && res_q.kind == KIND_RAW, res_q.value[31:8] == '0 && res_q.pos == '0 && !res_q.over)
  `EFVD_ASSERT_IMP(a_bound_clear, pop_o && head_i.op == OP_BOUND, ##1 (await_q && cnt_q == '0 && !ovf_q && acc_q == '0))

endmodule

// File: rtl/escaped_frame_varint_deframer_top.sv
// Escaped-frame varint deframer.
// Input channel: one raw log byte per transfer (byte_in_i), accepted at a
// rising edge with in_valid_i high and in_stall_o low. Byte 250 opens a new
// frame, byte 249 escapes the next byte; the first decoded byte of a frame is
// its channel id. Channels 96..98 pass bytes out raw, all others build 32-bit
// words from big-endian 7-bit groups.
// Output channel: one result per transfer (kind_o, channel_o, value_o,
// word_position_o, over_limit_o), taken at an edge with out_valid_o high and
// out_stall_i low. Kind 0 is a data word, kind 1 a raw byte, kind 2 frame end.
// Path: a byte that gives a result is written by the front decode into the op
// queue at its transfer edge, and the back update later registers its result
// in the output register.
// Throughput: one byte per cycle unless the output stalls; set by back update.
// Reset: rst_ni low clears escape, channel, word state, the op queue and the
// output valid; bytes before any frame start run on channel 0.
// Stall: while the receiver stalls a valid result, the output register holds it,
// the back side stops popping, and the two-entry op queue fills; in_stall_o rises
// once the queue is full, so no byte is lost.
module escaped_frame_varint_deframer_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                byte_in_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                kind_o,
  output logic [7:0]                channel_o,
  output logic [31:0]               value_o,
  output logic [efvd_pkg::PosW-1:0] word_position_o,
  output logic                      over_limit_o
);
  import efvd_pkg::*;

  logic push, q_full, q_valid, pop;
  op_t  push_op, head;
  res_t res;

  // classify bytes and strip escapes
  efvd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .byte_in_i  (byte_in_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .op_o       (push_op)
  );

  // decouple front from back
  efvd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (q_full),
    .pop_i     (pop),
    .valid_o   (q_valid),
    .head_o    (head)
  );

  // frame, channel and word state; output register
  efvd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign kind_o          = res.kind;
  assign channel_o       = res.chan;
  assign value_o         = res.value;
  assign word_position_o = res.pos;
  assign over_limit_o    = res.over;

endmodule
